// ===== rtl/hbtd_pkg.sv =====
// Package for the hot branch target detector.
// Holds shared constants, register indexes, the controller state type and the
// command and status structs. No dependencies.
`timescale 1ns / 1ps

package hbtd_pkg;

  // Default sizing handed to the top level
  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int COUNT_BITS_DEF    = 16;

  // Stream payload widths
  localparam int ADDR_W          = 64;
  localparam int IN_TDATA_W      = 2 * ADDR_W;
  localparam int OUT_TDATA_W     = ADDR_W;
  localparam int OUT_TUSER_W     = 2;
  localparam int OUT_USER_START  = 0;
  localparam int OUT_USER_FULL   = 1;

  // Configuration port
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int THRESH_W    = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_COUNT_MODE    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_HOT_THRESHOLD = 8'd1;

  localparam logic [THRESH_W-1:0] HOT_THRESHOLD_RESET = 16'd50;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } hbtd_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the input item, restart the table scan
    logic scan;    // issue the next table read and check the previous one
    logic commit;  // update the table and load the output register
  } hbtd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;       // checked entry matches the target
    logic scan_end;  // all used entries checked without a match
    logic out_free;  // output register can take a result this cycle
  } hbtd_sts_t;

endpackage

// ===== rtl/hbtd_ctrl.sv =====
// Controller for the hot branch target detector.
// Sequences accept, table scan and commit; depends on hbtd_pkg.
`timescale 1ns / 1ps

module hbtd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  hbtd_pkg::hbtd_sts_t sts,
  output hbtd_pkg::hbtd_cmd_t cmd
);

  hbtd_pkg::hbtd_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hbtd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    case (state_r)
      hbtd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = hbtd_pkg::ST_SCAN;
        end
      end
      hbtd_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit || sts.scan_end) begin
          state_nxt = hbtd_pkg::ST_COMMIT;
        end
      end
      hbtd_pkg::ST_COMMIT: begin
        // wait for room in the output register
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = hbtd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hbtd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/hbtd_dp.sv =====
// Datapath for the hot branch target detector.
// Config registers, tag and count tables, scan pointer, update logic and the
// output register; depends on hbtd_pkg.
`timescale 1ns / 1ps

module hbtd_dp #(
  parameter int TABLE_ENTRIES = hbtd_pkg::TABLE_ENTRIES_DEF,
  parameter int COUNT_BITS    = hbtd_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [hbtd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [hbtd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [hbtd_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  hbtd_pkg::hbtd_cmd_t                 cmd,
  output hbtd_pkg::hbtd_sts_t                 sts,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [hbtd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [hbtd_pkg::OUT_TUSER_W-1:0]    out_tuser
);

  localparam int AW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int UW   = $clog2(TABLE_ENTRIES + 1);
  localparam int MW   = COUNT_BITS + 1;
  localparam int CMPW = (COUNT_BITS > hbtd_pkg::THRESH_W) ? COUNT_BITS : hbtd_pkg::THRESH_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [UW-1:0]         USED_MAX  = UW'(TABLE_ENTRIES);

  // Configuration registers
  logic                          count_mode_r;
  logic [hbtd_pkg::THRESH_W-1:0] hot_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_mode_r <= 1'b0;
      hot_thr_r    <= hbtd_pkg::HOT_THRESHOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        hbtd_pkg::CFG_IDX_COUNT_MODE:    count_mode_r <= cfg_data[0];
        hbtd_pkg::CFG_IDX_HOT_THRESHOLD: hot_thr_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured item
  logic [hbtd_pkg::ADDR_W-1:0] target_r;
  logic                        counted_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      target_r  <= in_tdata[hbtd_pkg::ADDR_W-1:0];
      counted_r <= count_mode_r ||
                   (in_tdata[hbtd_pkg::ADDR_W-1:0] < in_tdata[hbtd_pkg::IN_TDATA_W-1:hbtd_pkg::ADDR_W]);
    end
  end

  // Table memories: tags and {recorded, count}
  logic [hbtd_pkg::ADDR_W-1:0] tag_mem  [TABLE_ENTRIES];
  logic [MW-1:0]               meta_mem [TABLE_ENTRIES];
  logic [hbtd_pkg::ADDR_W-1:0] tag_rd_r;
  logic [MW-1:0]               meta_rd_r;

  logic [UW-1:0] used_r, used_nxt;
  logic [UW-1:0] scan_ptr_r, scan_ptr_nxt;
  logic [AW-1:0] chk_ptr_r;
  logic          chk_vld_r, chk_vld_nxt;
  logic          rd_en;

  logic          tag_we, meta_we;
  logic [AW-1:0] wr_addr;
  logic [MW-1:0] wr_meta;

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[wr_addr] <= target_r;
    end
    if (meta_we) begin
      meta_mem[wr_addr] <= wr_meta;
    end
    if (rd_en) begin
      tag_rd_r  <= tag_mem[scan_ptr_r[AW-1:0]];
      meta_rd_r <= meta_mem[scan_ptr_r[AW-1:0]];
    end
  end

  // Scan: one read issued per cycle, checked on the next
  logic hit;

  assign rd_en = cmd.scan && (scan_ptr_r < used_r);
  assign hit   = chk_vld_r && (tag_rd_r == target_r);

  always_comb begin
    scan_ptr_nxt = scan_ptr_r;
    chk_vld_nxt  = chk_vld_r;
    if (cmd.load) begin
      scan_ptr_nxt = '0;
      chk_vld_nxt  = 1'b0;
    end else if (cmd.scan) begin
      chk_vld_nxt = rd_en;
      if (rd_en) begin
        scan_ptr_nxt = scan_ptr_r + UW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_ptr_r <= '0;
      chk_vld_r  <= 1'b0;
    end else begin
      scan_ptr_r <= scan_ptr_nxt;
      chk_vld_r  <= chk_vld_nxt;
    end
    if (rd_en) begin
      chk_ptr_r <= scan_ptr_r[AW-1:0];
    end
  end

  // Matched entry
  logic                  hit_r;
  logic [AW-1:0]         slot_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic                  rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd.load) begin
      hit_r <= 1'b0;
    end else if (cmd.scan && hit) begin
      hit_r <= 1'b1;
    end
    if (cmd.scan && hit) begin
      slot_r <= chk_ptr_r;
      cnt_r  <= meta_rd_r[COUNT_BITS-1:0];
      rec_r  <= meta_rd_r[COUNT_BITS];
    end
  end

  // Update of the entry and the result
  logic                  full;
  logic                  store_new;
  logic [COUNT_BITS-1:0] cnt_new;
  logic                  start;
  logic                  full_flag;

  assign full      = (used_r == USED_MAX);
  assign store_new = !hit_r && counted_r && !full;
  assign full_flag = !hit_r && counted_r && full;

  always_comb begin
    cnt_new = '0;
    start   = 1'b0;
    if (hit_r) begin
      cnt_new = cnt_r;
      if (counted_r && (cnt_r != COUNT_MAX)) begin
        cnt_new = cnt_r + COUNT_BITS'(1);
      end
      start = !rec_r && (CMPW'(cnt_new) >= CMPW'(hot_thr_r));
    end else if (store_new) begin
      start = (hot_thr_r == '0);
    end
  end

  assign wr_addr = hit_r ? slot_r : used_r[AW-1:0];
  assign wr_meta = {(hit_r && rec_r) || start, cnt_new};
  assign tag_we  = cmd.commit && store_new;
  assign meta_we = cmd.commit && (hit_r || store_new);

  assign used_nxt = tag_we ? used_r + UW'(1) : used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  // Output register
  logic                        out_vld_r;
  logic                        out_start_r;
  logic                        out_full_r;
  logic [hbtd_pkg::ADDR_W-1:0] out_region_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.commit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
    if (cmd.commit) begin
      out_start_r  <= start;
      out_full_r   <= full_flag;
      out_region_r <= start ? target_r : '0;
    end
  end

  assign out_tvalid                          = out_vld_r;
  assign out_tdata                           = out_region_r;
  assign out_tuser[hbtd_pkg::OUT_USER_START] = out_start_r;
  assign out_tuser[hbtd_pkg::OUT_USER_FULL]  = out_full_r;

  // Status
  assign sts.hit      = hit;
  assign sts.scan_end = !hit && (scan_ptr_r >= used_r);
  assign sts.out_free = !out_vld_r || out_tready;

`ifndef SYNTH
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_MAX)
    else $error("entry count beyond table size");

  a_start_xor_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_start_r && out_full_r))
    else $error("start request and table full in one result");

  a_region_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_start_r) |-> (out_region_r == '0))
    else $error("region address set without start request");

  a_new_entry: assert property (@(posedge clk) disable iff (!rst_n)
    tag_we |=> (used_r == $past(used_r) + UW'(1)))
    else $error("new entry did not advance entry count");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_vld_r || out_tready))
    else $error("commit while output register is occupied");
`endif

endmodule

// ===== rtl/hot_branch_target_detector.sv =====
// Hot branch target detector: a table scan looks up the target, then a commit
// step adjusts the count of a found entry or may store a new one. The result
// is loaded into the output register at commit, which waits for it to be free.
// A new input item is accepted only in the idle state, after the previous
// result is committed; the scan reads one tag memory entry per cycle.
// Synchronous active-low reset sets config to its defaults, clears the entry
// count and handshakes; no clearing pass, tables are read only below the count.
`timescale 1ns / 1ps

module hot_branch_target_detector #(
  parameter int TABLE_ENTRIES = hbtd_pkg::TABLE_ENTRIES_DEF,
  parameter int COUNT_BITS    = hbtd_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hbtd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hbtd_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [hbtd_pkg::IN_TDATA_W-1:0]  in_tdata,   // [63:0] target_address, [127:64] current_address
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [hbtd_pkg::OUT_TDATA_W-1:0] out_tdata,  // [63:0] region_address
  output logic [hbtd_pkg::OUT_TUSER_W-1:0] out_tuser   // [0] start_recording, [1] table_full
);

  hbtd_pkg::hbtd_cmd_t cmd;
  hbtd_pkg::hbtd_sts_t sts;

  // config registers take a write every cycle
  assign cfg_ready = 1'b1;

  hbtd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hbtd_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COUNT_BITS    (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
